/* sv/vps_pkg.sv */
`timescale 1ns / 1ps
// vps_pkg: shared types, mode codes and the varint encoding function
// for the packet field serialiser; no dependencies

package vps_pkg;

    localparam int VARINT_MAX_BYTES = 5;
    localparam int FIXED_MAX_BYTES  = 8;

    typedef enum logic [2:0]
    {
        MODE_U8     = 3'd0,
        MODE_U16    = 3'd1,
        MODE_U32    = 3'd2,
        MODE_U64    = 3'd3,
        MODE_VARINT = 3'd4,
        MODE_HEADER = 3'd5
    } vps_mode_t;

    typedef struct packed
    {
        logic [VARINT_MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                       len;     // 1..5
    } varint_t;

    // one encoded item: first segment (fixed field or first varint),
    // second segment (id varint in header mode)
    typedef struct packed
    {
        logic [FIXED_MAX_BYTES-1:0][7:0]  seg0;
        logic [3:0]                       n0;
        logic [VARINT_MAX_BYTES-1:0][7:0] seg1;
        logic [2:0]                       n1;
        logic [3:0]                       total;
    } vps_enc_t;

    // 7-bit groups, least significant first, continuation bit on all but the last
    function automatic varint_t varint_encode(logic [31:0] v);
        varint_t    r;
        logic [6:0] grp;
        r.len = 3'd1;
        if (v[31:28] != 4'd0)
            r.len = 3'd5;
        else if (v[27:21] != 7'd0)
            r.len = 3'd4;
        else if (v[20:14] != 7'd0)
            r.len = 3'd3;
        else if (v[13:7] != 7'd0)
            r.len = 3'd2;
        for (int k = 0; k < VARINT_MAX_BYTES; k++)
        begin
            if (k == VARINT_MAX_BYTES - 1)
                grp = {3'd0, v[31:28]};
            else
                grp = v[7*k +: 7];
            r.bytes[k] = {(3'(k) < (r.len - 3'd1)), grp};
        end
        return r;
    endfunction

endpackage

/* sv/vps_encode.sv */
`timescale 1ns / 1ps
// vps_encode: combinational byte layout of one input item
// depends on vps_pkg (mode codes, varint_encode, vps_enc_t)

module vps_encode
(
    input  logic [2:0]              mode,
    input  logic [63:0]             value,
    input  vps_pkg::varint_t        id_code,
    output vps_pkg::vps_enc_t       enc
);
    import vps_pkg::*;

    logic [31:0] hdr_len;
    varint_t     val_code;
    varint_t     len_code;

    // header length counts the id varint as well, wraps at 32 bits
    assign hdr_len  = value[31:0] + {29'd0, id_code.len};
    assign val_code = varint_encode(value[31:0]);
    assign len_code = varint_encode(hdr_len);

    always_comb
    begin
        enc.seg0 = '0;
        enc.n0   = 4'd0;
        enc.seg1 = '0;
        enc.n1   = 3'd0;
        case (mode)
            MODE_U8:
            begin
                enc.seg0[0] = value[7:0];
                enc.n0      = 4'd1;
            end
            MODE_U16:
            begin
                for (int k = 0; k < 2; k++)
                    enc.seg0[k] = value[8*(1-k) +: 8];
                enc.n0 = 4'd2;
            end
            MODE_U32:
            begin
                for (int k = 0; k < 4; k++)
                    enc.seg0[k] = value[8*(3-k) +: 8];
                enc.n0 = 4'd4;
            end
            MODE_U64:
            begin
                for (int k = 0; k < 8; k++)
                    enc.seg0[k] = value[8*(7-k) +: 8];
                enc.n0 = 4'd8;
            end
            MODE_VARINT:
            begin
                enc.seg0 = {24'd0, val_code.bytes};
                enc.n0   = {1'b0, val_code.len};
            end
            MODE_HEADER:
            begin
                enc.seg0 = {24'd0, len_code.bytes};
                enc.n0   = {1'b0, len_code.len};
                enc.seg1 = id_code.bytes;
                enc.n1   = id_code.len;
            end
            default:
            begin
                enc.n0 = 4'd0;
            end
        endcase
        enc.total = enc.n0 + {1'b0, enc.n1};
    end

endmodule

/* sv/varint_packet_field_serializer.sv */
`timescale 1ns / 1ps
// path: an accepted item goes through the input register, the byte buffer and the output register to m_tdata
// throughput: one output byte per cycle while m_tready is high; an item has 1..10 bytes
// and the input register can take the next item meanwhile; modes 6 and 7 yield no bytes
// reset (rst_n, asynchronous, active low): pipeline empties, packet id returns to 0
// depends on vps_pkg and vps_encode

module varint_packet_field_serializer
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration: packet id, written on any cycle with cfg_wr_en high
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [63:0] value
    input  logic [2:0]  s_tuser,    // [2:0] mode

    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast     // final byte of this input transaction
);
    import vps_pkg::*;

    // packet id is only ever needed in its varint form, so it is kept encoded
    varint_t     id_code_reg;

    // input register
    logic        a_valid_reg;
    logic [2:0]  a_mode_reg;
    logic [63:0] a_value_reg;

    // byte buffer of the item being emitted
    logic        b_valid_reg;
    vps_enc_t    b_enc_reg;
    logic [3:0]  b_ptr_reg;

    // output register
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    vps_enc_t    a_enc;
    logic        a_empty;       // unused mode, yields no bytes
    logic        a_move;
    logic        out_load;
    logic        b_last;
    logic        b_done;
    logic        b_free;
    logic [3:0]  seg1_idx;
    logic [7:0]  cur_byte;

    vps_encode u_encode
    (
        .mode    (a_mode_reg),
        .value   (a_value_reg),
        .id_code (id_code_reg),
        .enc     (a_enc)
    );

    // handshake control
    assign out_load = b_valid_reg && (!out_valid_reg || m_tready);
    assign b_last   = (b_ptr_reg == (b_enc_reg.total - 4'd1));
    assign b_done   = out_load && b_last;
    assign b_free   = !b_valid_reg || b_done;
    assign a_empty  = (a_enc.total == 4'd0);
    assign a_move   = a_valid_reg && (b_free || a_empty);
    assign s_tready = !a_valid_reg || a_move;

    // pick the current byte: first segment, then the id segment
    assign seg1_idx = b_ptr_reg - b_enc_reg.n0;

    always_comb
    begin
        if (b_ptr_reg < b_enc_reg.n0)
        begin
            cur_byte = b_enc_reg.seg0[b_ptr_reg[2:0]];
        end
        else
        begin
            case (seg1_idx[2:0])
                3'd0:    cur_byte = b_enc_reg.seg1[0];
                3'd1:    cur_byte = b_enc_reg.seg1[1];
                3'd2:    cur_byte = b_enc_reg.seg1[2];
                3'd3:    cur_byte = b_enc_reg.seg1[3];
                3'd4:    cur_byte = b_enc_reg.seg1[4];
                default: cur_byte = 8'd0;
            endcase
        end
    end

    // packet id register (encoded at write time, reset value encodes 0)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_code_reg <= varint_encode(32'd0);
        end
        else if (cfg_wr_en)
        begin
            id_code_reg <= varint_encode(cfg_wr_data);
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            a_mode_reg  <= s_tuser;
            a_value_reg <= s_tdata;
        end
    end

    // byte buffer: refilled in the same cycle its last byte leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_ptr_reg   <= 4'd0;
        end
        else if (a_move && !a_empty)
        begin
            b_valid_reg <= 1'b1;
            b_ptr_reg   <= 4'd0;
        end
        else if (b_done)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            b_ptr_reg <= b_ptr_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move && !a_empty)
        begin
            b_enc_reg <= a_enc;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= b_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    // a loaded buffer always has at least one byte to send
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_enc_reg.total != 4'd0))
    else $error("byte buffer holds an empty item");

    // read pointer stays inside the loaded item
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_ptr_reg < b_enc_reg.total))
    else $error("byte pointer past end of item");

    // a held input item is not dropped while the buffer is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !s_tready) |=> a_valid_reg)
    else $error("stalled input item lost");

    // encoded id is always a legal varint length
    assert property (@(posedge clk) disable iff (!rst_n)
        (id_code_reg.len != 3'd0) && (id_code_reg.len <= 3'd5))
    else $error("packet id varint length out of range");

endmodule
